### src/carpid_pkg.sv
// Package for the cascade angle/rate PID: control word layout, field codes,
// the microprogram ROM and the 32-bit saturation helper. No dependencies.
`default_nettype none

package carpid_pkg;

   // multiplier A operand
   localparam logic [2:0] A_ERR      = 3'd0;
   localparam logic [2:0] A_NEG_RATE = 3'd1;
   localparam logic [2:0] A_OFILT    = 3'd2;
   localparam logic [2:0] A_OINT     = 3'd3;
   localparam logic [2:0] A_IINT     = 3'd4;
   localparam logic [2:0] A_IFILT    = 3'd5;
   localparam logic [2:0] A_DRATE    = 3'd6;

   // multiplier B operand: gains, then fixed coefficients
   localparam logic [3:0] B_G_OP  = 4'd0;
   localparam logic [3:0] B_G_OI  = 4'd1;
   localparam logic [3:0] B_G_OD  = 4'd2;
   localparam logic [3:0] B_G_IP  = 4'd3;
   localparam logic [3:0] B_G_II  = 4'd4;
   localparam logic [3:0] B_G_ID  = 4'd5;
   localparam logic [3:0] B_MILLI = 4'd6;
   localparam logic [3:0] B_OLD   = 4'd7;
   localparam logic [3:0] B_NEW   = 4'd8;
   localparam logic [3:0] B_K1000 = 4'd9;

   localparam logic [24:0] K_MILLI_Q26 = 25'd67109;
   localparam logic [24:0] K_OLD_Q16   = 25'd26214;
   localparam logic [24:0] K_NEW_Q16   = 25'd39322;
   localparam logic [24:0] K_1000      = 25'd1000;

   // accumulator operation on the registered product
   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   // product scaling before accumulation
   localparam logic [1:0] SH_0   = 2'd0;
   localparam logic [1:0] SH_16  = 2'd1;
   localparam logic [1:0] SH_26R = 2'd2;

   // write-back from the accumulator
   localparam logic [2:0] WB_NONE  = 3'd0;
   localparam logic [2:0] WB_OINT  = 3'd1;
   localparam logic [2:0] WB_OFILT = 3'd2;
   localparam logic [2:0] WB_RT    = 3'd3;
   localparam logic [2:0] WB_IFILT = 3'd4;
   localparam logic [2:0] WB_IINT  = 3'd5;
   localparam logic [2:0] WB_DRIVE = 3'd6;
   localparam logic [2:0] WB_CLEAR = 3'd7;

   // sequencing
   localparam logic [1:0] JMP_NEXT  = 2'd0;
   localparam logic [1:0] JMP_CLEAR = 2'd1;
   localparam logic [1:0] JMP_DONE  = 2'd2;

   localparam int unsigned STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_CLEAR = 4'd14;

   typedef struct packed {
      logic              mul_en;
      logic [2:0]        a_sel;
      logic [3:0]        b_sel;
      logic [1:0]        acc_op;
      logic [1:0]        shift;
      logic [2:0]        wb;
      logic [1:0]        jmp;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] addr);
      ctrl_word_type cw;
      cw = '{1'b0, A_ERR, B_G_OP, ACC_NONE, SH_0, WB_NONE, JMP_DONE, 4'd0};
      case (addr)
         // outer angle loop
         4'd0:  cw = '{1'b1, A_ERR, B_MILLI, ACC_NONE, SH_0, WB_NONE, JMP_CLEAR, STEP_CLEAR};
         4'd1:  cw = '{1'b1, A_OFILT, B_OLD, ACC_LOAD, SH_26R, WB_NONE, JMP_NEXT, 4'd0};
         4'd2:  cw = '{1'b1, A_NEG_RATE, B_NEW, ACC_LOAD, SH_0, WB_OINT, JMP_NEXT, 4'd0};
         4'd3:  cw = '{1'b1, A_ERR, B_G_OP, ACC_ADD, SH_0, WB_NONE, JMP_NEXT, 4'd0};
         4'd4:  cw = '{1'b1, A_OINT, B_G_OI, ACC_LOAD, SH_16, WB_OFILT, JMP_NEXT, 4'd0};
         4'd5:  cw = '{1'b1, A_OFILT, B_G_OD, ACC_ADD, SH_16, WB_NONE, JMP_NEXT, 4'd0};
         4'd6:  cw = '{1'b0, A_ERR, B_G_OP, ACC_ADD, SH_16, WB_NONE, JMP_NEXT, 4'd0};
         // inner rate loop
         4'd7:  cw = '{1'b1, A_DRATE, B_K1000, ACC_NONE, SH_0, WB_RT, JMP_NEXT, 4'd0};
         4'd8:  cw = '{1'b1, A_ERR, B_MILLI, ACC_LOAD, SH_0, WB_NONE, JMP_NEXT, 4'd0};
         4'd9:  cw = '{1'b1, A_ERR, B_G_IP, ACC_LOAD, SH_26R, WB_IFILT, JMP_NEXT, 4'd0};
         4'd10: cw = '{1'b1, A_IFILT, B_G_ID, ACC_LOAD, SH_16, WB_IINT, JMP_NEXT, 4'd0};
         4'd11: cw = '{1'b1, A_IINT, B_G_II, ACC_ADD, SH_16, WB_NONE, JMP_NEXT, 4'd0};
         4'd12: cw = '{1'b0, A_ERR, B_G_OP, ACC_ADD, SH_16, WB_NONE, JMP_NEXT, 4'd0};
         4'd13: cw = '{1'b0, A_ERR, B_G_OP, ACC_NONE, SH_0, WB_DRIVE, JMP_DONE, 4'd0};
         // clear transaction
         4'd14: cw = '{1'b0, A_ERR, B_G_OP, ACC_NONE, SH_0, WB_CLEAR, JMP_DONE, 4'd0};
         default: cw = '{1'b0, A_ERR, B_G_OP, ACC_NONE, SH_0, WB_NONE, JMP_DONE, 4'd0};
      endcase
      return cw;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF)
         r = 32'sh7FFF_FFFF;
      else if (v < -64'sh0000_0000_8000_0000)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

### src/cascade_angle_rate_pid.sv
// Cascade angle/rate PID for one axis: sequencer, shared multiplier datapath,
// gain registers and result register. Depends on carpid_pkg.
`default_nettype none

// A control transaction is accepted and then runs 14 microprogram steps to
// its result; a clear transaction runs the first step and the clear step and
// gives no result. All arithmetic goes through one 33 x 25 bit multiplier whose
// product is registered, driven by a 15-word microprogram ROM, so the step
// count of that program sets the rate. One transaction is processed at a time;
// req_stall is high while the program runs, and the final step waits if the
// previous result has not yet been taken. Gains are written through the csr
// port while the block is idle; indexes 6 and 7 are ignored.
module cascade_angle_rate_pid #(
   parameter int INTEGRAL_LIMIT = 500
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_action,
   input  wire  signed [31:0]  req_target_angle,
   input  wire  signed [31:0]  req_measured_angle,
   input  wire  signed [31:0]  req_measured_rate,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic signed [31:0]  rsp_drive,
   output logic signed [31:0]  rsp_rate_target,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire         [2:0]   csr_index,
   input  wire         [23:0]  csr_data
);

   localparam longint LIMIT_Q = longint'(INTEGRAL_LIMIT) * 65536;
   localparam logic signed [63:0] ROUND16 = 64'sd32768;
   localparam logic signed [63:0] ROUND26 = 64'sd33554432;
   localparam int NUM_GAINS = 6;

   // sequencer
   logic                              busy_ff, busy_in;
   logic [carpid_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                              action_ff, action_in;
   carpid_pkg::ctrl_word_type         cw;
   logic                              hold, advance, accept;

   // datapath registers
   logic signed [32:0]  err_ff, err_in;
   logic signed [31:0]  rate_ff, rate_in;
   logic signed [57:0]  prod_ff, prod_in;
   logic signed [63:0]  acc_ff, acc_in;
   logic signed [31:0]  rt_ff, rt_in;

   // controller state
   logic signed [31:0]  oint_ff, oint_in;
   logic signed [31:0]  ofilt_ff, ofilt_in;
   logic signed [31:0]  iint_ff, iint_in;
   logic signed [31:0]  prev_ff, prev_in;
   logic signed [31:0]  ifilt_ff, ifilt_in;

   logic [23:0]         gain_ff [NUM_GAINS];

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  drive_ff, drive_in;
   logic signed [31:0]  rtout_ff, rtout_in;

   logic signed [32:0]  a_op;
   logic signed [24:0]  b_op;
   logic signed [32:0]  rate_ext;
   logic signed [63:0]  prod_ext, prod_scaled;
   logic signed [63:0]  int_sum, int_clamped, filt_tmp;
   logic signed [31:0]  int_base, rt_sat;

   assign cw        = carpid_pkg::ucode(step_ff);
   assign hold      = (cw.wb == carpid_pkg::WB_DRIVE) && rsp_valid_ff && rsp_stall;
   assign advance   = busy_ff && !hold;
   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;
   assign csr_ready = !busy_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive       = drive_ff;
   assign rsp_rate_target = rtout_ff;

   assign rate_ext = {rate_ff[31], rate_ff};

   // operand selection
   always_comb begin
      case (cw.a_sel)
         carpid_pkg::A_ERR:      a_op = err_ff;
         carpid_pkg::A_NEG_RATE: a_op = 33'sd0 - rate_ext;
         carpid_pkg::A_OFILT:    a_op = {ofilt_ff[31], ofilt_ff};
         carpid_pkg::A_OINT:     a_op = {oint_ff[31], oint_ff};
         carpid_pkg::A_IINT:     a_op = {iint_ff[31], iint_ff};
         carpid_pkg::A_IFILT:    a_op = {ifilt_ff[31], ifilt_ff};
         carpid_pkg::A_DRATE:    a_op = {prev_ff[31], prev_ff} - rate_ext;
         default:                a_op = '0;
      endcase
      case (cw.b_sel)
         carpid_pkg::B_G_OP:  b_op = {1'b0, gain_ff[0]};
         carpid_pkg::B_G_OI:  b_op = {1'b0, gain_ff[1]};
         carpid_pkg::B_G_OD:  b_op = {1'b0, gain_ff[2]};
         carpid_pkg::B_G_IP:  b_op = {1'b0, gain_ff[3]};
         carpid_pkg::B_G_II:  b_op = {1'b0, gain_ff[4]};
         carpid_pkg::B_G_ID:  b_op = {1'b0, gain_ff[5]};
         carpid_pkg::B_MILLI: b_op = carpid_pkg::K_MILLI_Q26;
         carpid_pkg::B_OLD:   b_op = carpid_pkg::K_OLD_Q16;
         carpid_pkg::B_NEW:   b_op = carpid_pkg::K_NEW_Q16;
         carpid_pkg::B_K1000: b_op = carpid_pkg::K_1000;
         default:             b_op = '0;
      endcase
   end

   assign prod_in  = a_op * b_op;
   assign prod_ext = {{6{prod_ff[57]}}, prod_ff};

   // scaling is floor; the integral increment rounds half up first
   always_comb begin
      case (cw.shift)
         carpid_pkg::SH_0:   prod_scaled = prod_ext;
         carpid_pkg::SH_16:  prod_scaled = prod_ext >>> 16;
         carpid_pkg::SH_26R: prod_scaled = (prod_ext + ROUND26) >>> 26;
         default:            prod_scaled = prod_ext;
      endcase
   end

   always_comb begin
      case (cw.acc_op)
         carpid_pkg::ACC_LOAD: acc_in = prod_scaled;
         carpid_pkg::ACC_ADD:  acc_in = acc_ff + prod_scaled;
         default:              acc_in = acc_ff;
      endcase
   end

   // shared integrator clamp, filter and rate-target saturation
   assign int_base = (cw.wb == carpid_pkg::WB_IINT) ? iint_ff : oint_ff;
   assign int_sum  = 64'(int_base) + acc_ff;
   always_comb begin
      if (int_sum > LIMIT_Q)
         int_clamped = LIMIT_Q;
      else if (int_sum < -LIMIT_Q)
         int_clamped = -LIMIT_Q;
      else
         int_clamped = int_sum;
   end

   assign filt_tmp = (cw.wb == carpid_pkg::WB_IFILT) ? ((64'(ifilt_ff) + acc_ff) >>> 1)
                                                     : ((acc_ff + ROUND16) >>> 16);
   assign rt_sat   = carpid_pkg::sat32(acc_ff);

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      action_in    = action_ff;
      err_in       = err_ff;
      rate_in      = rate_ff;
      rt_in        = rt_ff;
      oint_in      = oint_ff;
      ofilt_in     = ofilt_ff;
      iint_in      = iint_ff;
      prev_in      = prev_ff;
      ifilt_in     = ifilt_ff;
      drive_in     = drive_ff;
      rtout_in     = rtout_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (accept) begin
         busy_in   = 1'b1;
         step_in   = '0;
         action_in = req_action;
         err_in    = {req_target_angle[31], req_target_angle}
                     - {req_measured_angle[31], req_measured_angle};
         rate_in   = req_measured_rate;
      end

      if (advance) begin
         case (cw.wb)
            carpid_pkg::WB_OINT:  oint_in  = int_clamped[31:0];
            carpid_pkg::WB_IINT:  iint_in  = int_clamped[31:0];
            carpid_pkg::WB_OFILT: ofilt_in = carpid_pkg::sat32(filt_tmp);
            carpid_pkg::WB_IFILT: begin
               ifilt_in = carpid_pkg::sat32(filt_tmp);
               prev_in  = rate_ff;
            end
            carpid_pkg::WB_RT: begin
               rt_in  = rt_sat;
               err_in = {rt_sat[31], rt_sat} - rate_ext;
            end
            carpid_pkg::WB_DRIVE: begin
               drive_in     = carpid_pkg::sat32(acc_ff);
               rtout_in     = rt_ff;
               rsp_valid_in = 1'b1;
            end
            carpid_pkg::WB_CLEAR: begin
               oint_in = '0;
               iint_in = '0;
            end
            default: ;
         endcase
         case (cw.jmp)
            carpid_pkg::JMP_CLEAR: step_in = action_ff ? cw.target : step_ff + 1'b1;
            carpid_pkg::JMP_DONE: begin
               busy_in = 1'b0;
               step_in = '0;
            end
            default: step_in = step_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         action_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         oint_ff      <= '0;
         ofilt_ff     <= '0;
         iint_ff      <= '0;
         prev_ff      <= '0;
         ifilt_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         action_ff    <= action_in;
         rsp_valid_ff <= rsp_valid_in;
         oint_ff      <= oint_in;
         ofilt_ff     <= ofilt_in;
         iint_ff      <= iint_in;
         prev_ff      <= prev_in;
         ifilt_ff     <= ifilt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      rate_ff  <= rate_in;
      rt_ff    <= rt_in;
      drive_ff <= drive_in;
      rtout_ff <= rtout_in;
      if (advance && cw.mul_en)
         prod_ff <= prod_in;
      if (advance)
         acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_GAINS; i++)
            gain_ff[i] <= '0;
      end else if (csr_valid && csr_ready && (int'(csr_index) < NUM_GAINS)) begin
         gain_ff[csr_index] <= csr_data;
      end
   end

`ifndef SYNTHESIS
   a_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (step_ff == '0))
      else $error("sequencer idle away from the first step");

   a_result_ends_program: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> !busy_ff)
      else $error("result raised while the program still runs");

   a_oint_bound: assert property (@(posedge clock) disable iff (reset)
      (longint'(oint_ff) <= LIMIT_Q) && (longint'(oint_ff) >= -LIMIT_Q))
      else $error("outer integrator beyond its limit");

   a_iint_bound: assert property (@(posedge clock) disable iff (reset)
      (longint'(iint_ff) <= LIMIT_Q) && (longint'(iint_ff) >= -LIMIT_Q))
      else $error("inner integrator beyond its limit");

   a_hold_keeps_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && hold) |=> (busy_ff && $stable(step_ff)))
      else $error("sequencer moved while the last step was held");
`endif

endmodule

`default_nettype wire
